/* sv/dlp_pkg.sv */
// Shared types and constants for the distance LOD priority block.
// No dependencies; used by the cells and the top level.
package dlp_pkg;

    localparam int COORD_BITS_DEF     = 24;
    localparam int PRIO_FRAC_BITS_DEF = 14;
    localparam int LIMIT_W            = 25;              // cull limit, band start
    localparam int CLAMP_BITS         = 26;              // axis magnitude clamp 2^26
    localparam int MAG_W              = CLAMP_BITS + 1;  // clamped magnitude
    localparam int SUM_W              = 2 * MAG_W;       // sum of three squares
    localparam int RT_W               = MAG_W;           // square root width
    localparam int RM_W               = RT_W + 2;        // root remainder width
    localparam int PRIO_W             = 16;

    // Register indexes on the config port
    typedef enum logic [1:0] {
        REG_OBS_X = 2'd0,
        REG_OBS_Y = 2'd1,
        REG_OBS_Z = 2'd2,
        REG_CULL  = 2'd3
    } t_reg_idx;

    // One beat moving down the square-root chain
    typedef struct packed {
        logic               valid;
        logic               forced;
        logic [LIMIT_W-1:0] imp;
        logic [SUM_W-1:0]   n;
        logic [RM_W-1:0]    rem;
        logic [RT_W-1:0]    root;
    } t_sq;

    // Control tag moving down the divider chain
    typedef struct packed {
        logic valid;
        logic forced;
    } t_tag;

endpackage

/* sv/dlp_sqrt_cell.sv */
// One bit of the pipelined restoring integer square root.
// Depends on dlp_pkg.
module dlp_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  dlp_pkg::t_sq  i_sq,
    output dlp_pkg::t_sq  o_sq
);
    import dlp_pkg::*;

    logic [RM_W-1:0] w_cand;
    logic [RM_W-1:0] w_trial;
    t_sq             n_sq;
    t_sq             r_sq;

    always_comb begin
        w_cand  = RM_W'({i_sq.rem, i_sq.n[SUM_W-1 -: 2]});
        w_trial = RM_W'({i_sq.root, 2'b01});
        n_sq    = i_sq;
        n_sq.n  = {i_sq.n[SUM_W-3:0], 2'b00};
        if (w_cand >= w_trial) begin
            n_sq.rem  = w_cand - w_trial;
            n_sq.root = {i_sq.root[RT_W-2:0], 1'b1};
        end else begin
            n_sq.rem  = w_cand;
            n_sq.root = {i_sq.root[RT_W-2:0], 1'b0};
        end
    end

    // only the valid bit is reset; data follows the enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.valid <= 1'b0;
        end else if (i_en) begin
            r_sq.valid <= n_sq.valid;
        end
        if (i_en) begin
            r_sq.forced <= n_sq.forced;
            r_sq.imp    <= n_sq.imp;
            r_sq.n      <= n_sq.n;
            r_sq.rem    <= n_sq.rem;
            r_sq.root   <= n_sq.root;
        end
    end

    assign o_sq = r_sq;

endmodule

/* sv/dlp_div_cell.sv */
// One quotient bit of the pipelined restoring divider.
// Depends on dlp_pkg.
module dlp_div_cell #(
    parameter int RW = dlp_pkg::LIMIT_W + 1,
    parameter int QW = dlp_pkg::PRIO_FRAC_BITS_DEF + 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  dlp_pkg::t_tag               i_tag,
    input  logic [dlp_pkg::LIMIT_W-1:0] i_den,
    input  logic [RW-1:0]               i_rem,
    input  logic [QW-1:0]               i_num_lo,
    input  logic [QW-1:0]               i_quo,
    output dlp_pkg::t_tag               o_tag,
    output logic [dlp_pkg::LIMIT_W-1:0] o_den,
    output logic [RW-1:0]               o_rem,
    output logic [QW-1:0]               o_num_lo,
    output logic [QW-1:0]               o_quo
);
    import dlp_pkg::*;

    logic [RW:0]   w_rem2;
    logic [RW:0]   w_den;
    logic          w_ge;
    t_tag          r_tag;
    logic [LIMIT_W-1:0] r_den;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_num_lo;
    logic [QW-1:0] r_quo;

    assign w_rem2 = {i_rem, i_num_lo[QW-1]};
    assign w_den  = (RW+1)'(i_den);
    assign w_ge   = (w_rem2 >= w_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_tag.valid <= i_tag.valid;
        end
        if (i_en) begin
            r_tag.forced <= i_tag.forced;
            r_den        <= i_den;
            r_rem        <= w_ge ? RW'(w_rem2 - w_den) : RW'(w_rem2);
            r_num_lo     <= {i_num_lo[QW-2:0], 1'b0};
            r_quo        <= {i_quo[QW-2:0], w_ge};
        end
    end

    assign o_tag    = r_tag;
    assign o_den    = r_den;
    assign o_rem    = r_rem;
    assign o_num_lo = r_num_lo;
    assign o_quo    = r_quo;

endmodule

/* sv/distance_lod_priority_top.sv */
// Distance LOD priority top level: front stages, square-root chain, divider chain.
// Depends on dlp_pkg, dlp_sqrt_cell and dlp_div_cell.

// One object per beat goes in, one priority beat comes out, and a new beat is
// taken every cycle while the pipe is not held. The pipe has three front stages
// (axis magnitude, squares, sum), one cell per root bit of the square root, one
// setup stage and one cell per quotient bit of the divider. The whole pipe
// moves as one; it holds only when a finished beat sits at the output and the
// sink is not ready. Config writes (observer position, cull limit) take effect
// at once and must only be made while the pipe is empty. Priority is unsigned
// with PRIO_FRAC_BITS fraction bits (Q2.14 and 2.0 = 32768 by default),
// truncated; is_culled and is_visible follow it.
module distance_lod_priority_top #(
    parameter int  COORD_BITS     = dlp_pkg::COORD_BITS_DEF,
    parameter int  PRIO_FRAC_BITS = dlp_pkg::PRIO_FRAC_BITS_DEF,
    localparam int CFG_W = (COORD_BITS > dlp_pkg::LIMIT_W) ? COORD_BITS : dlp_pkg::LIMIT_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_data,
    // object in
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [COORD_BITS-1:0]       i_obj_x,
    input  logic [COORD_BITS-1:0]       i_obj_y,
    input  logic [COORD_BITS-1:0]       i_obj_z,
    input  logic [dlp_pkg::LIMIT_W-1:0] i_impostor_start,
    input  logic                        i_forced,
    // priority out
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [dlp_pkg::PRIO_W-1:0]  o_lod_priority,
    output logic                        o_is_culled,
    output logic                        o_is_visible
);
    import dlp_pkg::*;

    localparam int DW    = COORD_BITS + 1;            // signed difference
    localparam int QW    = PRIO_FRAC_BITS + 2;        // quotient bits
    localparam int BW    = LIMIT_W + 1;               // numerator base
    localparam int NUM_W = BW + PRIO_FRAC_BITS + 1;
    localparam int RW    = NUM_W - QW;                // divider remainder

    // ---------------- config registers ----------------
    logic [COORD_BITS-1:0] r_obs_x, r_obs_y, r_obs_z;
    logic [LIMIT_W-1:0]    r_cull;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_x <= '0;
            r_obs_y <= '0;
            r_obs_z <= '0;
            r_cull  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_OBS_X: r_obs_x <= i_cfg_data[COORD_BITS-1:0];
                REG_OBS_Y: r_obs_y <= i_cfg_data[COORD_BITS-1:0];
                REG_OBS_Z: r_obs_z <= i_cfg_data[COORD_BITS-1:0];
                REG_CULL:  r_cull  <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: the pipe moves unless the output beat is stuck.
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // ---------------- stage 0: clamped axis magnitudes ----------------
    logic [COORD_BITS-1:0] w_obj [3];
    logic [COORD_BITS-1:0] w_obs [3];
    logic [DW-1:0]         w_diff [3];
    logic [DW-1:0]         w_abs [3];
    logic [31:0]           w_abs32 [3];
    logic [MAG_W-1:0]      n_mag [3];

    assign w_obj[0] = i_obj_x;
    assign w_obj[1] = i_obj_y;
    assign w_obj[2] = i_obj_z;
    assign w_obs[0] = r_obs_x;
    assign w_obs[1] = r_obs_y;
    assign w_obs[2] = r_obs_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_diff[a]  = {w_obj[a][COORD_BITS-1], w_obj[a]}
                       - {w_obs[a][COORD_BITS-1], w_obs[a]};
            w_abs[a]   = w_diff[a][DW-1] ? DW'(-w_diff[a]) : w_diff[a];
            w_abs32[a] = 32'(w_abs[a]);
            n_mag[a]   = (w_abs32[a] > (32'd1 << CLAMP_BITS))
                       ? MAG_W'(32'd1 << CLAMP_BITS) : w_abs32[a][MAG_W-1:0];
        end
    end

    t_tag               r_s0_tag, r_s1_tag, r_s2_tag;
    logic [LIMIT_W-1:0] r_s0_imp, r_s1_imp, r_s2_imp;
    logic [MAG_W-1:0]   r_mag [3];
    logic [SUM_W-1:0]   r_sqr [3];
    logic [SUM_W-1:0]   r_sum;

    // stage 1: squares, stage 2: sum of squares; only valid bits are reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_tag.valid <= 1'b0;
            r_s1_tag.valid <= 1'b0;
            r_s2_tag.valid <= 1'b0;
        end else if (w_en) begin
            r_s0_tag.valid <= i_valid;
            r_s1_tag.valid <= r_s0_tag.valid;
            r_s2_tag.valid <= r_s1_tag.valid;
        end
        if (w_en) begin
            r_s0_tag.forced <= i_forced;
            r_s0_imp        <= i_impostor_start;
            for (int a = 0; a < 3; a++) begin
                r_mag[a] <= n_mag[a];
                r_sqr[a] <= SUM_W'(r_mag[a]) * SUM_W'(r_mag[a]);
            end
            r_s1_tag.forced <= r_s0_tag.forced;
            r_s1_imp        <= r_s0_imp;
            r_sum           <= r_sqr[0] + r_sqr[1] + r_sqr[2];
            r_s2_tag.forced <= r_s1_tag.forced;
            r_s2_imp        <= r_s1_imp;
        end
    end

    // ---------------- square-root chain ----------------
    t_sq w_sq [RT_W+1];

    assign w_sq[0].valid  = r_s2_tag.valid;
    assign w_sq[0].forced = r_s2_tag.forced;
    assign w_sq[0].imp    = r_s2_imp;
    assign w_sq[0].n      = r_sum;
    assign w_sq[0].rem    = '0;
    assign w_sq[0].root   = '0;

    for (genvar g = 0; g < RT_W; g++) begin : g_sqrt
        dlp_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_sq    (w_sq[g]),
            .o_sq    (w_sq[g+1])
        );
    end

    // ---------------- divider setup ----------------
    // Forced: 2<<F / 1. Culled: 0 / 1. Otherwise one of the three falloffs.
    t_sq                w_sr;
    logic [RT_W:0]      w_c_ext;
    logic [RT_W:0]      w_d_ext;
    logic [RT_W:0]      w_imp_ext;
    logic [BW-1:0]      w_base;
    logic [NUM_W-1:0]   n_num;
    logic [LIMIT_W-1:0] n_den;

    assign w_sr      = w_sq[RT_W];
    assign w_c_ext   = (RT_W+1)'(r_cull);
    assign w_d_ext   = (RT_W+1)'(w_sr.root);
    assign w_imp_ext = (RT_W+1)'(w_sr.imp);

    always_comb begin
        w_base = '0;
        n_num  = '0;
        n_den  = LIMIT_W'(1);
        if (w_sr.forced) begin
            n_num = NUM_W'(2) << PRIO_FRAC_BITS;
        end else if (w_d_ext >= w_c_ext) begin
            n_num = '0;
        end else if (w_sr.imp == '0) begin
            w_base = BW'(w_c_ext - w_d_ext);
            n_num  = NUM_W'(w_base) << (PRIO_FRAC_BITS + 1);
            n_den  = r_cull;
        end else if (w_d_ext >= w_imp_ext) begin
            w_base = BW'(w_c_ext - w_d_ext);
            n_num  = NUM_W'(w_base) << (PRIO_FRAC_BITS - 1);
            n_den  = r_cull - w_sr.imp;
        end else begin
            w_base = BW'((w_imp_ext << 1) - w_d_ext);
            n_num  = NUM_W'(w_base) << PRIO_FRAC_BITS;
            n_den  = w_sr.imp;
        end
    end

    // ---------------- divider chain ----------------
    t_tag               w_dtag [QW+1];
    logic [LIMIT_W-1:0] w_dden [QW+1];
    logic [RW-1:0]      w_drem [QW+1];
    logic [QW-1:0]      w_dnum [QW+1];
    logic [QW-1:0]      w_dquo [QW+1];
    t_tag               r_su_tag;
    logic [LIMIT_W-1:0] r_su_den;
    logic [NUM_W-1:0]   r_su_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_su_tag.valid <= 1'b0;
        end else if (w_en) begin
            r_su_tag.valid <= w_sr.valid;
        end
        if (w_en) begin
            r_su_tag.forced <= w_sr.forced;
            r_su_den        <= n_den;
            r_su_num        <= n_num;
        end
    end

    // Quotient fits QW bits, so the top part of the numerator is already below den.
    assign w_dtag[0] = r_su_tag;
    assign w_dden[0] = r_su_den;
    assign w_drem[0] = r_su_num[NUM_W-1:QW];
    assign w_dnum[0] = r_su_num[QW-1:0];
    assign w_dquo[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_div
        dlp_div_cell #(
            .RW (RW),
            .QW (QW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_tag    (w_dtag[g]),
            .i_den    (w_dden[g]),
            .i_rem    (w_drem[g]),
            .i_num_lo (w_dnum[g]),
            .i_quo    (w_dquo[g]),
            .o_tag    (w_dtag[g+1]),
            .o_den    (w_dden[g+1]),
            .o_rem    (w_drem[g+1]),
            .o_num_lo (w_dnum[g+1]),
            .o_quo    (w_dquo[g+1])
        );
    end

    // ---------------- output ----------------
    // The last divider cell is the output register; it holds while stalled.
    logic w_zero;
    assign w_zero         = (w_dquo[QW] == '0);
    assign o_valid        = w_dtag[QW].valid;
    assign o_lod_priority = PRIO_W'(w_dquo[QW]);
    assign o_is_culled    = w_zero && !w_dtag[QW].forced;
    assign o_is_visible   = !w_zero || w_dtag[QW].forced;

    // ---------------- assertions ----------------
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("pipe not empty after reset");

    a_forced_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && w_dtag[QW].forced |-> o_is_visible && !o_is_culled)
        else $error("forced object not visible");

    a_culled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_culled |-> o_lod_priority == '0)
        else $error("culled object with nonzero priority");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_su_tag.valid && o_valid && !i_ready |=> r_su_tag.valid && $stable(r_su_num))
        else $error("divider setup moved during stall");

endmodule
